/* rtl/core/raabb_pkg.sv */
// Shared types and register indexes for the ray versus box slab test.
`default_nettype none
package raabb_pkg;

    localparam int unsigned CfgIndexWidth = 3;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5
    } reg_idx_t;

    // Per axis flags that ride along with the quotients.
    typedef struct packed {
        logic dzero;
        logic in_slab;
    } axis_flags_t;

endpackage
`default_nettype wire

/* rtl/core/ray_aabb_slab_entry_distance.sv */
// Ray against one axis-aligned box, slab method, fully pipelined.
//
// The box is set through the write port (cfg_wr_en, cfg_index, cfg_wdata):
// three centers and three half extents, all cleared by reset. Write them only
// while no request is in flight. Each request on the s_ channel carries a ray
// origin and direction; each one yields exactly one result on the m_ channel,
// a hit flag and the largest entry parameter (zero on a miss).
// From acceptance to m_valid the path runs as follows: the input
// register loads at the accepting edge, then come three preparation stages,
// one restoring-division stage per quotient bit, a sign and saturation stage,
// an ordering stage and two interval stages. Six dividers run side by side,
// so one request enters every cycle unless the output stalls, and results
// leave at the same rate. The long division chain sets the latency.
// A synchronous active-low reset empties the pipeline. When the receiver holds
// m_ready low with a result waiting, the whole pipeline holds and s_ready
// drops; nothing is lost or repeated, and a request can enter in the cycle
// the result is taken.
`default_nettype none
module ray_aabb_slab_entry_distance
    import raabb_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_wr_en,
    input  wire  [CfgIndexWidth-1:0]         cfg_index,
    input  wire  [COORD_WIDTH-1:0]           cfg_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  signed [COORD_WIDTH-1:0]    s_origin_x,
    input  wire  signed [COORD_WIDTH-1:0]    s_origin_y,
    input  wire  signed [COORD_WIDTH-1:0]    s_origin_z,
    input  wire  signed [COORD_WIDTH-1:0]    s_dir_x,
    input  wire  signed [COORD_WIDTH-1:0]    s_dir_y,
    input  wire  signed [COORD_WIDTH-1:0]    s_dir_z,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_hit,
    output logic signed [COORD_WIDTH-1:0]    m_entry_distance
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 2;
    localparam int AW   = CW + 1;
    localparam int NW   = AW + FRAC_BITS;
    localparam int HIW  = NW - CW;
    localparam int CMPW = (HIW > CW) ? HIW : CW;
    localparam logic signed [CW-1:0] TMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] TMIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        logic [CW-1:0] rem;
        logic [CW-1:0] low;
        logic [CW-1:0] quo;
        logic [CW-1:0] den;
        logic          sat;
        logic          neg;
    } lane_t;

    typedef struct packed {
        lane_t [5:0]       lane;
        axis_flags_t [2:0] ax;
    } div_item_t;

    logic advance;
    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // Box registers and the plane positions derived from them.
    logic signed [CW-1:0] center_reg [3];
    logic [CW-2:0]        half_reg   [3];
    logic signed [CW:0]   plane_lo_reg [3];
    logic signed [CW:0]   plane_hi_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                center_reg[a] <= '0;
                half_reg[a]   <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CENTER_X: center_reg[0] <= cfg_wdata;
                REG_CENTER_Y: center_reg[1] <= cfg_wdata;
                REG_CENTER_Z: center_reg[2] <= cfg_wdata;
                REG_HALF_X:   half_reg[0]   <= cfg_wdata[CW-2:0];
                REG_HALF_Y:   half_reg[1]   <= cfg_wdata[CW-2:0];
                REG_HALF_Z:   half_reg[2]   <= cfg_wdata[CW-2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++) begin
            plane_lo_reg[a] <= {center_reg[a][CW-1], center_reg[a]} - {2'b00, half_reg[a]};
            plane_hi_reg[a] <= {center_reg[a][CW-1], center_reg[a]} + {2'b00, half_reg[a]};
        end
    end

    // Stage 1: input register.
    logic                 v1_reg;
    logic signed [CW-1:0] org1_reg [3];
    logic signed [CW-1:0] dir1_reg [3];

    // Stage 2: plane differences and direction magnitude.
    logic                 v2_reg;
    logic signed [DW-1:0] diff2_reg [6];
    logic [CW-1:0]        dmag2_reg [3];
    logic                 dneg2_reg [3];
    axis_flags_t          ax2_reg   [3];

    // Stage 3: numerator magnitudes and quotient signs.
    logic                 v3_reg;
    logic [AW-1:0]        nmag3_reg [6];
    logic                 neg3_reg  [6];
    logic [CW-1:0]        dmag3_reg [3];
    axis_flags_t          ax3_reg   [3];

    // Stage 4 onward: division lanes.
    logic                 v4_reg;
    div_item_t            div4_reg;
    logic [CW-1:0]        vit_reg;
    div_item_t            it_reg  [CW];
    div_item_t            it_next [CW];

    logic                 v5_reg;
    logic signed [CW-1:0] t5_reg [6];
    axis_flags_t          ax5_reg [3];

    logic                 v6_reg;
    logic signed [CW-1:0] lo6_reg [3];
    logic signed [CW-1:0] hi6_reg [3];
    logic                 ok6_reg [3];

    logic                 v7_reg;
    logic signed [CW-1:0] tmin7_reg;
    logic signed [CW-1:0] tmax7_reg;
    logic signed [CW-1:0] lo7_reg;
    logic signed [CW-1:0] hi7_reg;
    logic                 ok7_reg;

    logic                 m_valid_reg;
    logic                 m_hit_reg;
    logic signed [CW-1:0] m_entry_reg;

    // Valid chain.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            vit_reg     <= '0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            vit_reg     <= {vit_reg[CW-2:0], v4_reg};
            v5_reg      <= vit_reg[CW-1];
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= v7_reg;
        end
    end

    // Front stages.
    always_ff @(posedge aclk) begin
        if (advance) begin
            org1_reg[0] <= s_origin_x;
            org1_reg[1] <= s_origin_y;
            org1_reg[2] <= s_origin_z;
            dir1_reg[0] <= s_dir_x;
            dir1_reg[1] <= s_dir_y;
            dir1_reg[2] <= s_dir_z;

            for (int a = 0; a < 3; a++) begin
                diff2_reg[2*a]   <= {plane_lo_reg[a][CW], plane_lo_reg[a]}
                                    - {{2{org1_reg[a][CW-1]}}, org1_reg[a]};
                diff2_reg[2*a+1] <= {plane_hi_reg[a][CW], plane_hi_reg[a]}
                                    - {{2{org1_reg[a][CW-1]}}, org1_reg[a]};
                dmag2_reg[a]     <= dir1_reg[a][CW-1] ? (CW'(0) - dir1_reg[a]) : dir1_reg[a];
                dneg2_reg[a]     <= dir1_reg[a][CW-1];
                ax2_reg[a].dzero <= (dir1_reg[a] == '0);
                ax2_reg[a].in_slab <=
                    ($signed({org1_reg[a][CW-1], org1_reg[a]}) >= plane_lo_reg[a]) &&
                    ($signed({org1_reg[a][CW-1], org1_reg[a]}) <= plane_hi_reg[a]);
            end

            for (int l = 0; l < 6; l++) begin
                nmag3_reg[l] <= diff2_reg[l][DW-1] ? AW'(DW'(0) - diff2_reg[l])
                                                   : AW'(diff2_reg[l]);
                neg3_reg[l]  <= diff2_reg[l][DW-1] ^ dneg2_reg[l/2];
            end
            for (int a = 0; a < 3; a++) begin
                dmag3_reg[a] <= dmag2_reg[a];
                ax3_reg[a]   <= ax2_reg[a];
            end
        end
    end

    // Stage 4: the integer part of the scaled numerator decides saturation
    // and seeds the remainder; the low bits are fed in one per stage.
    div_item_t div4_next;
    always_comb begin
        logic [NW-1:0]  num;
        logic [HIW-1:0] num_hi;
        for (int l = 0; l < 6; l++) begin
            num    = {nmag3_reg[l], {FRAC_BITS{1'b0}}};
            num_hi = num[NW-1:CW];
            div4_next.lane[l].sat = (CMPW'(num_hi) >= CMPW'(dmag3_reg[l/2]));
            div4_next.lane[l].rem = CW'(num_hi);
            div4_next.lane[l].low = num[CW-1:0];
            div4_next.lane[l].quo = '0;
            div4_next.lane[l].den = dmag3_reg[l/2];
            div4_next.lane[l].neg = neg3_reg[l];
        end
        for (int a = 0; a < 3; a++) begin
            div4_next.ax[a] = ax3_reg[a];
        end
    end

    // One quotient bit per stage, restoring division.
    always_comb begin
        div_item_t    src;
        logic [CW:0]   rsh;
        logic [CW+1:0] sub;
        for (int k = 0; k < CW; k++) begin
            src = (k == 0) ? div4_reg : it_reg[(k == 0) ? 0 : k - 1];
            it_next[k] = src;
            for (int l = 0; l < 6; l++) begin
                rsh = {src.lane[l].rem, src.lane[l].low[CW-1]};
                sub = {1'b0, rsh} - {2'b00, src.lane[l].den};
                it_next[k].lane[l].rem = sub[CW+1] ? rsh[CW-1:0] : sub[CW-1:0];
                it_next[k].lane[l].quo = {src.lane[l].quo[CW-2:0], !sub[CW+1]};
                it_next[k].lane[l].low = {src.lane[l].low[CW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            div4_reg <= div4_next;
            for (int k = 0; k < CW; k++) begin
                it_reg[k] <= it_next[k];
            end
        end
    end

    // Sign, saturation, slab ordering and interval intersection.
    always_ff @(posedge aclk) begin
        lane_t                ln;
        logic signed [CW-1:0] ta;
        logic signed [CW-1:0] tb;
        logic                 ok;
        if (advance) begin
            for (int l = 0; l < 6; l++) begin
                ln = it_reg[CW-1].lane[l];
                if (ln.neg) begin
                    if (ln.sat || (ln.quo[CW-1] && (|ln.quo[CW-2:0]))) begin
                        t5_reg[l] <= TMIN;
                    end else begin
                        t5_reg[l] <= CW'(0) - ln.quo;
                    end
                end else if (ln.sat || ln.quo[CW-1]) begin
                    t5_reg[l] <= TMAX;
                end else begin
                    t5_reg[l] <= ln.quo;
                end
            end
            for (int a = 0; a < 3; a++) begin
                ax5_reg[a] <= it_reg[CW-1].ax[a];
            end

            for (int a = 0; a < 3; a++) begin
                ta = t5_reg[2*a];
                tb = t5_reg[2*a+1];
                if (ax5_reg[a].dzero) begin
                    lo6_reg[a] <= TMIN;
                    hi6_reg[a] <= TMAX;
                    ok6_reg[a] <= ax5_reg[a].in_slab;
                end else begin
                    lo6_reg[a] <= (tb < ta) ? tb : ta;
                    hi6_reg[a] <= (tb < ta) ? ta : tb;
                    ok6_reg[a] <= 1'b1;
                end
            end

            tmin7_reg <= (lo6_reg[1] > lo6_reg[0]) ? lo6_reg[1] : lo6_reg[0];
            tmax7_reg <= (hi6_reg[1] < hi6_reg[0]) ? hi6_reg[1] : hi6_reg[0];
            lo7_reg   <= lo6_reg[2];
            hi7_reg   <= hi6_reg[2];
            ok7_reg   <= ok6_reg[0] && ok6_reg[1] && ok6_reg[2] &&
                         !(lo6_reg[0] > hi6_reg[1] || lo6_reg[1] > hi6_reg[0]);

            ok = ok7_reg && !(tmin7_reg > hi7_reg || lo7_reg > tmax7_reg);
            m_hit_reg   <= ok;
            m_entry_reg <= !ok ? '0 : ((lo7_reg > tmin7_reg) ? lo7_reg : tmin7_reg);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_entry_distance = m_entry_reg;

`ifndef SYNTH
    a_miss_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_entry_distance == '0))
        else $error("miss result carries a nonzero entry distance");

    a_empty_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_input_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (v7_reg == $past(v7_reg)))
        else $error("pipeline moved while the output stalled");
`endif

endmodule
`default_nettype wire

/* tb/ray_aabb_checker.sv */
// Checker for the ray versus box block: predicts each result and compares it.
module ray_aabb_checker
    import raabb_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               cfg_wr_en,
    input  wire  [2:0]        cfg_index,
    input  wire  [31:0]       cfg_wdata,
    input  wire               s_valid,
    input  wire               s_ready,
    input  wire  [31:0]       s_origin_x,
    input  wire  [31:0]       s_origin_y,
    input  wire  [31:0]       s_origin_z,
    input  wire  [31:0]       s_dir_x,
    input  wire  [31:0]       s_dir_y,
    input  wire  [31:0]       s_dir_z,
    input  wire               m_valid,
    input  wire               m_ready,
    input  wire               m_hit,
    input  wire  [31:0]       m_entry_distance,
    output int                fail_count,
    output int                pending_count,
    output int                hit_count,
    output int                miss_count
);

    localparam longint TMAX = 64'sd2147483647;
    localparam longint TMIN = -64'sd2147483648;

    typedef struct packed {
        logic        hit;
        logic [31:0] distance;
    } box_result_t;

    box_result_t expected_q[$];
    logic signed [31:0] box_center[3];
    logic [30:0]        box_half[3];

    // Fixed point quotient, truncated toward zero and saturated.
    function automatic longint fixed_quotient(longint num, longint den);
        longint unsigned an, ad, q, r, cap;
        logic neg;
        an  = (num < 0) ? -num : num;
        ad  = (den < 0) ? -den : den;
        cap = 64'd1 << 32;
        q   = an / ad;
        r   = an % ad;
        neg = (num < 0) != (den < 0);
        if (q > cap) q = cap;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ad) begin
                r = r - ad;
                q = q | 1;
            end
            if (q > cap) q = cap;
        end
        if (neg) begin
            if (q > 64'd2147483648) return TMIN;
            return -longint'(q);
        end
        if (q > 64'd2147483647) return TMAX;
        return longint'(q);
    endfunction

    // Interval of one slab; returns 0 when the ray cannot meet it.
    function automatic logic slab_interval(int ax, logic [31:0] o_raw, logic [31:0] d_raw,
                                           output longint lo, output longint hi);
        longint c, h, o, d, pl, ph, a, b, t;
        c  = longint'(box_center[ax]);
        h  = longint'({1'b0, box_half[ax]});
        o  = longint'($signed(o_raw));
        d  = longint'($signed(d_raw));
        pl = c - h;
        ph = c + h;
        lo = TMIN;
        hi = TMAX;
        if (d == 0) return !(o < pl || o > ph);
        a = fixed_quotient(pl - o, d);
        b = fixed_quotient(ph - o, d);
        if (b < a) begin
            t = a; a = b; b = t;
        end
        lo = a;
        hi = b;
        return 1'b1;
    endfunction

    function automatic box_result_t predict_entry(logic [31:0] o[3], logic [31:0] d[3]);
        longint tmin, tmax, lo, hi;
        logic ok;
        box_result_t res;
        ok = slab_interval(0, o[0], d[0], tmin, tmax);
        for (int ax = 1; ax < 3 && ok; ax++) begin
            ok = slab_interval(ax, o[ax], d[ax], lo, hi);
            if (ok && (tmin > hi || lo > tmax)) ok = 1'b0;
            if (ok) begin
                if (lo > tmin) tmin = lo;
                if (hi < tmax) tmax = hi;
            end
        end
        res.hit      = ok;
        res.distance = ok ? tmin[31:0] : 32'd0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    assign pending_count = expected_q.size();

    initial begin
        fail_count = 0;
        hit_count  = 0;
        miss_count = 0;
    end

    always @(posedge aclk) begin
        box_result_t want;
        logic [31:0] o[3], d[3];
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                box_center[i] = '0;
                box_half[i]   = '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_CENTER_X: box_center[0] = cfg_wdata;
                    REG_CENTER_Y: box_center[1] = cfg_wdata;
                    REG_CENTER_Z: box_center[2] = cfg_wdata;
                    REG_HALF_X:   box_half[0]   = cfg_wdata[30:0];
                    REG_HALF_Y:   box_half[1]   = cfg_wdata[30:0];
                    REG_HALF_Z:   box_half[2]   = cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_entry_distance, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_hit !== want.hit) report_mismatch("hit", m_hit, want.hit);
                    if (m_entry_distance !== want.distance)
                        report_mismatch("entry_distance", m_entry_distance, want.distance);
                    if (want.hit) hit_count++; else miss_count++;
                end
            end
            if (s_valid && s_ready) begin
                o = '{s_origin_x, s_origin_y, s_origin_z};
                d = '{s_dir_x, s_dir_y, s_dir_z};
                expected_q.push_back(predict_entry(o, d));
            end
        end
    end

endmodule

/* tb/tb_ray_aabb_slab_entry_distance.sv */
// Top of the ray versus box testbench: clock, reset, stimulus and verdict.
module tb_ray_aabb_slab_entry_distance;
    import raabb_pkg::*;

    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk, aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid, s_ready;
    logic signed [31:0] s_origin_x, s_origin_y, s_origin_z, s_dir_x, s_dir_y, s_dir_z;
    logic        m_valid, m_ready, m_hit;
    logic signed [31:0] m_entry_distance;
    int          fail_count, pending_count, hit_count, miss_count;
    int          idle_cycles, rays_sent;
    logic        quiet_phase;

    ray_aabb_slab_entry_distance DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_entry_distance(m_entry_distance)
    );

    ray_aabb_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_origin_x(s_origin_x), .s_origin_y(s_origin_y), .s_origin_z(s_origin_z),
        .s_dir_x(s_dir_x), .s_dir_y(s_dir_y), .s_dir_z(s_dir_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_entry_distance(m_entry_distance),
        .fail_count(fail_count), .pending_count(pending_count),
        .hit_count(hit_count), .miss_count(miss_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: cycles without any accepted request or result, reset or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls in random bursts, none in the quiet phase.
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready = 1'b1;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                           logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
        wait_drained();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_HALF_X, hx);
        write_reg(REG_HALF_Y, hy);
        write_reg(REG_HALF_Z, hz);
    endtask

    // Presents one ray; called at a falling edge, returns at a falling edge.
    task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                            logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
        if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_origin_x = ox; s_origin_y = oy; s_origin_z = oz;
        s_dir_x = dx; s_dir_y = dy; s_dir_z = dz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid = 1'b0;
        rays_sent++;
    endtask

    function automatic logic [31:0] rand_coord(int unsigned kind);
        case (kind)
            0: return $urandom();
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3: return 32'd0;
            default: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        endcase
    endfunction

    // Mostly small coordinates and directions near the origin, with wild values and zero directions mixed in.
    task automatic random_rays(int count);
        logic [31:0] o[3], d[3];
        for (int n = 0; n < count; n++) begin
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(0, 9) == 0) begin
                    o[a] = rand_coord($urandom_range(0, 3));
                    d[a] = rand_coord($urandom_range(0, 3));
                end else begin
                    o[a] = rand_coord(4);
                    d[a] = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_coord(4);
                end
            end
            send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0; cfg_index = '0; cfg_wdata = '0;
        s_valid = 1'b0;
        s_origin_x = '0; s_origin_y = '0; s_origin_z = '0;
        s_dir_x = '0; s_dir_y = '0; s_dir_z = '0;
        idle_cycles = 0; rays_sent = 0; quiet_phase = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset box: a single point at the origin.
        send_ray(32'hffff_0000, 0, 0, 32'h0001_0000, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        set_box(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        // Zero direction inside and outside, all axes unlimited, edge on the plane.
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h0001_0000, 0, 0, 0, 0, 0);
        send_ray(32'h0001_0001, 0, 0, 0, 0, 0);
        send_ray(32'hfffb_0000, 0, 0, 32'h0001_0000, 0, 0);
        send_ray(32'h0005_0000, 0, 0, 32'hffff_0000, 0, 0);
        send_ray(32'hfffb_0000, 32'hfffb_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
        // Miss by disjoint slabs, touching intervals, tiny direction saturates.
        send_ray(32'hfff0_0000, 32'h0000_0000, 32'hfff0_0000, 32'h0001_0000, 0, 32'h0000_8000);
        send_ray(32'hfffe_0000, 32'hfffd_0000, 0, 32'h0001_0000, 32'h0001_0000, 0);
        send_ray(32'h8000_0000, 0, 0, 32'h0000_0001, 0, 0);
        send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                 32'h0000_0001, 32'h0000_0001);
        send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        // Extreme box settings.
        set_box(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0001_0000);
        send_ray(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0100);
        set_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        send_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        send_ray(0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);

        // Random phases over a few boxes.
        for (int p = 0; p < 5; p++) begin
            set_box(rand_coord(4), rand_coord(4), rand_coord(4),
                    $urandom_range(0, 32'h0008_0000), $urandom_range(0, 32'h0008_0000),
                    $urandom_range(0, 32'h0008_0000));
            random_rays(110);
            // Hold the sender until the pipeline has fully drained once.
            if (p == 2) while (pending_count != 0) @(negedge aclk);
        end
        set_box($urandom(), $urandom(), $urandom(),
                $urandom() >> 1, $urandom() >> 1, $urandom() >> 1);
        random_rays(60);
        set_box(0, 0, 0, $urandom_range(1, 32'h0004_0000), $urandom_range(1, 32'h0004_0000),
                $urandom_range(1, 32'h0004_0000));
        quiet_phase = 1'b1;
        random_rays(90);

        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
        $display("Sent %0d rays over the reset box and ten written boxes, extremes included.",
                 rays_sent);
        $display("Checked %0d hits and %0d misses.", hit_count, miss_count);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/raabb_pkg.sv
rtl/core/ray_aabb_slab_entry_distance.sv
tb/ray_aabb_checker.sv
tb/tb_ray_aabb_slab_entry_distance.sv
